// ===== sv/tmcw_pkg.sv =====
// ============================================================================
// tmcw_pkg: shared types and constants of the text-mode console writer
// Transaction payloads, command codes, controller states and the control and
// status bundles between the controller and the datapath.
// ============================================================================
package tmcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } command_t;

  typedef enum logic {
    REG_DEFAULT_FG = 1'b0,
    REG_BACKGROUND = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam int         TAB_STEP     = 4;

  localparam logic [3:0] RESET_FG = 4'd7;
  localparam logic [3:0] RESET_BG = 4'd0;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [3:0]  fg_colour;
    logic        end_of_text;
    logic [10:0] cell_address;
  } request_t;

  typedef struct packed {
    logic [10:0] shown_cursor_index;
    logic [15:0] cell_data;
    logic        scrolled;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_END,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SW_RESET,
    SW_CLEAR,
    SW_SCROLL
  } sweep_mode_t;

  typedef enum logic [1:0] {
    EMIT_PLAIN,
    EMIT_READ,
    EMIT_SWEEP
  } emit_kind_t;

  typedef struct packed {
    logic        apply;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
    logic        sweep_en;
    logic        emit;
    emit_kind_t  emit_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic put_scrolls;
    logic sweep_last;
  } dp_status_t;

endpackage

// ===== sv/tmcw_ctrl.sv =====
// ============================================================================
// tmcw_ctrl: controller of the text-mode console writer
// Sequences the clearing pass after reset, cell reads, and the scroll and
// clear sweeps, and tells the datapath when to apply and report a transaction.
// ============================================================================
module tmcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            command,
  input  tmcw_pkg::dp_status_t  status,
  output logic                  busy,
  output tmcw_pkg::ctrl_cmd_t   cmd
);

  tmcw_pkg::state_t   state;
  tmcw_pkg::state_t   state_next;
  tmcw_pkg::command_t op;

  assign op = tmcw_pkg::command_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmcw_pkg::ST_INIT: begin
        if (status.sweep_last) begin
          state_next = tmcw_pkg::ST_INIT_END;
        end
      end
      tmcw_pkg::ST_INIT_END: begin
        state_next = tmcw_pkg::ST_IDLE;
      end
      tmcw_pkg::ST_IDLE: begin
        if (start) begin
          if (op == tmcw_pkg::CMD_READ) begin
            state_next = tmcw_pkg::ST_READ;
          end else if (op == tmcw_pkg::CMD_CLEAR) begin
            state_next = tmcw_pkg::ST_SWEEP;
          end else if (op == tmcw_pkg::CMD_PUT && status.put_scrolls) begin
            state_next = tmcw_pkg::ST_SWEEP;
          end
        end
      end
      tmcw_pkg::ST_READ: begin
        state_next = tmcw_pkg::ST_IDLE;
      end
      tmcw_pkg::ST_SWEEP: begin
        if (status.sweep_last) begin
          state_next = tmcw_pkg::ST_FINISH;
        end
      end
      tmcw_pkg::ST_FINISH: begin
        state_next = tmcw_pkg::ST_IDLE;
      end
      default: begin
        state_next = tmcw_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    cmd.apply       = 1'b0;
    cmd.sweep_start = 1'b0;
    cmd.sweep_mode  = tmcw_pkg::SW_CLEAR;
    cmd.sweep_en    = 1'b0;
    cmd.emit        = 1'b0;
    cmd.emit_kind   = tmcw_pkg::EMIT_PLAIN;
    unique case (state)
      tmcw_pkg::ST_INIT: begin
        cmd.sweep_en = 1'b1;
      end
      tmcw_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.apply = start;
        if (start) begin
          if (op == tmcw_pkg::CMD_CLEAR) begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tmcw_pkg::SW_CLEAR;
          end else if (op == tmcw_pkg::CMD_PUT && status.put_scrolls) begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_mode  = tmcw_pkg::SW_SCROLL;
          end else if (op != tmcw_pkg::CMD_READ) begin
            cmd.emit = 1'b1;
          end
        end
      end
      tmcw_pkg::ST_READ: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = tmcw_pkg::EMIT_READ;
      end
      tmcw_pkg::ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
      end
      tmcw_pkg::ST_FINISH: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = tmcw_pkg::EMIT_SWEEP;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/tmcw_dp.sv =====
// ============================================================================
// tmcw_dp: datapath of the text-mode console writer
// Holds the cell store, the cursors, the colour registers, the sweep pointer
// and the result registers.
// ============================================================================
module tmcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tmcw_pkg::request_t    request,
  input  tmcw_pkg::ctrl_cmd_t   cmd,
  output tmcw_pkg::dp_status_t  status,
  output logic                  done,
  output tmcw_pkg::result_t     result,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [3:0]            cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int AXW   = (AW > 11) ? AW : 11;
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int TSH   = $clog2(tmcw_pkg::TAB_STEP);
  localparam int TAB_LAST_I = ((COLUMNS - 1) / tmcw_pkg::TAB_STEP) * tmcw_pkg::TAB_STEP;

  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]  COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [AXW-1:0] CELLS_X   = AXW'(CELLS);
  localparam logic [CLW:0]   COLS_W    = (CLW + 1)'(COLUMNS);
  localparam logic [CLW:0]   TAB_LAST  = (CLW + 1)'(TAB_LAST_I);
  localparam logic [RW:0]    ROWS_W    = (RW + 1)'(ROWS);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CLW-1:0] COL_LAST  = CLW'(COLUMNS - 1);

  function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] r, input logic [CLW-1:0] c);
    return AW'(r) * COLS_A + AW'(c);
  endfunction

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic [3:0]    fg_default;
  logic [3:0]    bg;

  logic [RW-1:0]  cur_row;
  logic [CLW-1:0] cur_col;
  logic [10:0]    vis;

  logic [AW-1:0]         ptr;
  tmcw_pkg::sweep_mode_t mode;
  logic                  pend_valid;
  logic                  pend_copy;
  logic [AW-1:0]         pend_addr;
  logic                  copy_now;

  logic          rd_ok;
  logic [15:0]   res_data;
  logic          res_scrolled;

  tmcw_pkg::command_t op;
  logic [AXW-1:0]     addr_x;
  logic               addr_ok;
  logic               printable;
  logic [CLW:0]       col_w;
  logic [CLW:0]       tab_t;
  logic [CLW:0]       col_inc;
  logic [RW:0]        row_tmp;
  logic [CLW-1:0]     col_tmp;
  logic [RW-1:0]      row_put;
  logic               put_scroll;
  logic [RW-1:0]      row_er;
  logic [CLW-1:0]     col_er;
  logic [AW-1:0]      cur_idx;
  logic [AW-1:0]      er_idx;
  logic [AW-1:0]      put_idx;
  logic [15:0]        user_blank;
  logic [15:0]        sweep_blank;

  assign op         = tmcw_pkg::command_t'(request.command);
  assign addr_x     = AXW'(request.cell_address);
  assign addr_ok    = addr_x < CELLS_X;
  assign user_blank = {bg, fg_default, tmcw_pkg::CH_SPACE};
  assign sweep_blank = (mode == tmcw_pkg::SW_RESET) ?
                       {tmcw_pkg::RESET_BG, tmcw_pkg::RESET_FG, tmcw_pkg::CH_SPACE} :
                       user_blank;
  assign cur_idx    = cell_index(cur_row, cur_col);
  assign copy_now   = (mode == tmcw_pkg::SW_SCROLL) && (ptr < COPY_END);

  assign printable = (request.char_code != tmcw_pkg::CH_BACKSPACE) &&
                     (request.char_code != tmcw_pkg::CH_TAB) &&
                     (request.char_code != tmcw_pkg::CH_NEWLINE) &&
                     (request.char_code != tmcw_pkg::CH_RETURN);

  always_comb begin
    col_w   = (CLW + 1)'(cur_col);
    tab_t   = ((col_w >> TSH) + (CLW + 1)'(1)) << TSH;
    col_inc = col_w + (CLW + 1)'(1);
    row_tmp = (RW + 1)'(cur_row);
    col_tmp = cur_col;
    priority if (request.char_code == tmcw_pkg::CH_BACKSPACE) begin
      if (cur_col != '0) begin
        col_tmp = cur_col - CLW'(1);
      end
    end else if (request.char_code == tmcw_pkg::CH_TAB) begin
      col_tmp = (tab_t >= COLS_W) ? TAB_LAST[CLW-1:0] : tab_t[CLW-1:0];
    end else if (request.char_code == tmcw_pkg::CH_NEWLINE) begin
      row_tmp = (RW + 1)'(cur_row) + (RW + 1)'(1);
      col_tmp = '0;
    end else if (request.char_code == tmcw_pkg::CH_RETURN) begin
      col_tmp = '0;
    end else begin
      if (col_inc >= COLS_W) begin
        row_tmp = (RW + 1)'(cur_row) + (RW + 1)'(1);
        col_tmp = '0;
      end else begin
        col_tmp = col_inc[CLW-1:0];
      end
    end
    put_scroll = row_tmp >= ROWS_W;
    row_put    = put_scroll ? ROW_LAST : row_tmp[RW-1:0];
    put_idx    = cell_index(row_put, col_tmp);
  end

  always_comb begin
    row_er = cur_row;
    col_er = cur_col;
    if (cur_col != '0) begin
      col_er = cur_col - CLW'(1);
    end else if (cur_row != '0) begin
      row_er = cur_row - RW'(1);
      col_er = COL_LAST;
    end
    er_idx = cell_index(row_er, col_er);
  end

  assign status.put_scrolls = put_scroll;
  assign status.sweep_last  = ptr == LAST_CELL;

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    wdata = sweep_blank;
    if (pend_valid) begin
      we    = 1'b1;
      wdata = pend_copy ? rdata : sweep_blank;
    end else if (cmd.apply && op == tmcw_pkg::CMD_PUT && printable) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = {bg, request.fg_colour, request.char_code};
    end else if (cmd.apply && op == tmcw_pkg::CMD_ERASE) begin
      we    = 1'b1;
      waddr = er_idx;
      wdata = user_blank;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = ptr + COLS_A;
    if (cmd.sweep_en && copy_now) begin
      re = 1'b1;
    end else if (cmd.apply && op == tmcw_pkg::CMD_READ && addr_ok) begin
      re    = 1'b1;
      raddr = addr_x[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_default <= tmcw_pkg::RESET_FG;
      bg         <= tmcw_pkg::RESET_BG;
    end else if (cfg_write) begin
      unique case (tmcw_pkg::cfg_reg_t'(cfg_index))
        tmcw_pkg::REG_DEFAULT_FG: fg_default <= cfg_data;
        tmcw_pkg::REG_BACKGROUND: bg         <= cfg_data;
        default:                  bg         <= bg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      vis     <= '0;
    end else if (cmd.apply) begin
      unique case (op)
        tmcw_pkg::CMD_PUT: begin
          cur_row <= row_put;
          cur_col <= col_tmp;
          if (request.end_of_text) begin
            vis <= 11'(put_idx);
          end
        end
        tmcw_pkg::CMD_ERASE: begin
          cur_row <= row_er;
          cur_col <= col_er;
          vis     <= 11'(er_idx);
        end
        tmcw_pkg::CMD_CLEAR: begin
          cur_row <= '0;
          cur_col <= '0;
          vis     <= '0;
        end
        tmcw_pkg::CMD_READ: begin
          vis <= vis;
        end
        default: begin
          vis <= vis;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      mode       <= tmcw_pkg::SW_RESET;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.sweep_start) begin
        ptr  <= '0;
        mode <= cmd.sweep_mode;
      end else if (cmd.sweep_en) begin
        ptr <= ptr + AW'(1);
      end
      pend_valid <= cmd.sweep_en;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
    pend_copy <= copy_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rd_ok <= (op == tmcw_pkg::CMD_READ) && addr_ok;
    end
    if (cmd.emit) begin
      res_data     <= (cmd.emit_kind == tmcw_pkg::EMIT_READ && rd_ok) ? rdata : 16'h0000;
      res_scrolled <= (cmd.emit_kind == tmcw_pkg::EMIT_SWEEP) &&
                      (mode == tmcw_pkg::SW_SCROLL);
    end
  end

  assign result.shown_cursor_index = vis;
  assign result.cell_data          = res_data;
  assign result.scrolled           = res_scrolled;

`ifndef NO_ASSERTIONS
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (RW + 1)'(cur_row) < ROWS_W)
    else $error("cursor row beyond last row");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (CLW + 1)'(cur_col) < COLS_W)
    else $error("cursor column beyond last column");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && cmd.apply))
    else $error("sweep write collides with a new transaction");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_en |-> !cmd.apply && !cmd.emit)
    else $error("transaction applied during a sweep");
`endif

endmodule

// ===== sv/text_mode_console_writer_top.sv =====
// ============================================================================
// text_mode_console_writer_top: ROWS x COLUMNS text console
// Put, erase, clear and read transactions on a 16-bit cell store with a
// logical cursor and a visible cursor. One result per transaction.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears on result for one cycle with done high and cannot be held off.
// Put without scroll and erase return the result in the next cycle and the
// block takes a new transaction right away; a read is bound by the registered
// read port of the cell store and reports its result from the ST_READ state.
// A scroll or clear walks the whole store one cell per cycle, and a scroll
// copies rows through that single port. After reset, busy stays high while
// the store is blanked; configuration writes are taken at any time.
// ============================================================================
module text_mode_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tmcw_pkg::request_t request,
  output logic               done,
  output tmcw_pkg::result_t  result,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  tmcw_pkg::ctrl_cmd_t  cmd;
  tmcw_pkg::dp_status_t status;

  tmcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  tmcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
